[rtl/bcpe_pkg.sv]
// Shared types and constants for the Bezier curve point evaluator.
// No dependencies; every other file imports this package.
package bcpe_pkg;

    localparam int COORD_BITS   = 16;
    localparam int T_FRAC_BITS  = 16;
    localparam int MAX_POINTS_D = 16;
    localparam int INDEX_BITS   = 4;
    localparam int COUNT_BITS   = 5;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(2);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic                          op;
        logic [INDEX_BITS-1:0]         point_index;
        logic signed [COORD_BITS-1:0]  point_x;
        logic signed [COORD_BITS-1:0]  point_y;
        logic [T_FRAC_BITS:0]          t_param;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  curve_x;
        logic signed [COORD_BITS-1:0]  curve_y;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
    } t_point;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic                   load;   // write store entry
        logic [INDEX_BITS-1:0]  index;  // entry that a load writes
        logic                   copy;   // store -> work copy
        logic                   shift;  // move work one cell toward cell 0
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DROP,
        S_OUT
    } t_state;

endpackage

[rtl/bcpe_cell.sv]
// One cell of the point row: holds a control point and a working point.
// Depends on bcpe_pkg.
module bcpe_cell
    import bcpe_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int LEN_BITS   = 5
) (
    input  logic                i_clk,
    input  t_cell_ctrl          i_ctrl,
    input  logic [LEN_BITS-1:0] i_len,
    input  t_point              i_load_pt,
    input  t_point              i_next_work,
    input  t_point              i_lerp_pt,
    output t_point              o_work
);

    t_point r_store, n_store;
    t_point r_work,  n_work;
    logic   w_tail;

    // This cell is the last one of the current level
    assign w_tail = (i_len == LEN_BITS'(CELL_INDEX + 1));

    always_comb begin
        n_store = r_store;
        n_work  = r_work;
        if (i_ctrl.load && (32'(i_ctrl.index) == CELL_INDEX)) begin
            n_store = i_load_pt;
        end
        if (i_ctrl.copy) begin
            n_work = r_store;
        end else if (i_ctrl.shift) begin
            n_work = w_tail ? i_lerp_pt : i_next_work;
        end
    end

    // Payload only: no reset
    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_work  <= n_work;
    end

    assign o_work = r_work;

endmodule

[rtl/bcpe_lerp.sv]
// Shared interpolation unit: a + round((b - a) * t), half away from zero.
// Product registered, add in the next cycle. Depends on bcpe_pkg.
module bcpe_lerp
    import bcpe_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  logic [T_FRAC_BITS:0]         i_t,
    output logic signed [COORD_BITS-1:0] o_res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = DW + T_FRAC_BITS + 1;
    localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

    logic signed [DW-1:0] w_d;
    logic [DW-1:0]        w_mag;
    logic [PW-1:0]        w_prod;

    logic signed [COORD_BITS-1:0] r_a, r_b;
    logic                         r_neg, r_one;
    logic [PW-1:0]                r_prod;

    logic [PW-1:0]        w_round;
    logic [DW-1:0]        w_q;
    logic signed [DW:0]   w_sum;

    // Stage 1: magnitude of the difference times t
    assign w_d    = DW'(i_b) - DW'(i_a);
    assign w_mag  = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);
    assign w_prod = PW'(w_mag) * PW'(i_t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_neg  <= w_d[DW-1];
            r_one  <= (i_t >= T_ONE);
            r_prod <= w_prod;
        end
    end

    // Stage 2: round, apply sign, add base
    assign w_round = r_prod + (PW'(1) << (T_FRAC_BITS - 1));
    assign w_q     = DW'(w_round >> T_FRAC_BITS);
    assign w_sum   = r_neg ? ((DW+1)'(r_a) - (DW+1)'(w_q))
                           : ((DW+1)'(r_a) + (DW+1)'(w_q));
    // Result lies between a and b, so the low bits are exact
    assign o_res   = r_one ? r_b : w_sum[COORD_BITS-1:0];

endmodule

[rtl/bezier_curve_point_eval.sv]
// Bezier curve point evaluator, top level: control, cell row, lerp units.
// Depends on bcpe_pkg, bcpe_cell, bcpe_lerp.
//
//   channel | valid      | stall       | payload
//   input   | i_in_valid | o_in_stall  | i_in_item  (t_in_item)
//   output  | o_out_valid| i_out_stall | o_out_item (t_out_item)
//   config  | i_cfg_we   | -           | i_cfg_data (point_count)
//
// A load writes one store entry. An evaluate with n points works through
// each de Casteljau level of L points in L-1 passes through the shared
// multiply/add unit, a multiply state then an add state each, plus one shift.
// Reset clears control state only; the point store is undefined until written.
// A result waits in the output register under stall while the next item enters.
module bezier_curve_point_eval
    import bcpe_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [COUNT_BITS-1:0] i_cfg_data
);

    localparam int LEN_BITS = $clog2(MAX_POINTS + 1);
    localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [LEN_BITS-1:0]   r_len, n_len;
    logic [LEN_BITS-1:0]   r_step, n_step;
    logic [T_FRAC_BITS:0]  r_t;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  w_accept;
    logic [LEN_BITS-1:0]   w_n;
    logic                  w_mul_en;
    t_cell_ctrl            w_ctrl;
    t_point                w_work [MAX_POINTS];
    t_point                w_lerp;
    t_point                w_load;

    assign w_accept = i_in_valid && !o_in_stall;

    // Clamp point count to 1..MAX_POINTS
    always_comb begin
        if (r_count == '0) begin
            w_n = LEN_BITS'(1);
        end else if (32'(r_count) > MAX_POINTS) begin
            w_n = LEN_BITS'(MAX_POINTS);
        end else begin
            w_n = LEN_BITS'(r_count);
        end
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    // Clamp and hold t on evaluate transfer
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_item.op == OP_EVAL) begin
            r_t <= (i_in_item.t_param > T_ONE) ? T_ONE : i_in_item.t_param;
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_ctrl      = '0;
        w_mul_en    = 1'b0;
        o_in_stall  = (r_state != S_IDLE);
        w_ctrl.index = i_in_item.point_index;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.op == OP_LOAD) begin
                        w_ctrl.load = 32'(i_in_item.point_index) < MAX_POINTS;
                    end else begin
                        w_ctrl.copy = 1'b1;
                        n_len       = w_n;
                        n_step      = '0;
                        n_state     = (w_n == LEN_BITS'(1)) ? S_OUT : S_MUL;
                    end
                end
            end
            S_MUL: begin
                w_mul_en = 1'b1;
                n_state  = S_ADD;
            end
            S_ADD: begin
                w_ctrl.shift = 1'b1;
                if (r_step == r_len - LEN_BITS'(2)) begin
                    n_state = S_DROP;
                end else begin
                    n_step  = r_step + LEN_BITS'(1);
                    n_state = S_MUL;
                end
            end
            S_DROP: begin
                w_ctrl.shift = 1'b1;
                n_len        = r_len - LEN_BITS'(1);
                n_step       = '0;
                n_state      = (r_len == LEN_BITS'(2)) ? S_OUT : S_MUL;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out.curve_x = w_work[0].x;
                    n_out.curve_y = w_work[0].y;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Shared interpolation, one unit per axis
    bcpe_lerp u_lerp_x (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_work[0].x),
        .i_b   (w_work[1].x),
        .i_t   (r_t),
        .o_res (w_lerp.x)
    );

    bcpe_lerp u_lerp_y (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_work[0].y),
        .i_b   (w_work[1].y),
        .i_t   (r_t),
        .o_res (w_lerp.y)
    );

    assign w_load.x = i_in_item.point_x;
    assign w_load.y = i_in_item.point_y;

    // Row of cells, each fed by its right neighbor; the last cell takes the lerp result
    for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
        t_point w_next;
        if (gi == MAX_POINTS - 1) begin : g_last
            assign w_next = w_lerp;
        end else begin : g_mid
            assign w_next = w_work[gi+1];
        end
        bcpe_cell #(
            .CELL_INDEX (gi),
            .LEN_BITS   (LEN_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_len       (r_len),
            .i_load_pt   (w_load),
            .i_next_work (w_next),
            .i_lerp_pt   (w_lerp),
            .o_work      (w_work[gi])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Interpolation runs only on levels of two or more points
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_ADD || r_state == S_DROP)
            |-> (r_len >= LEN_BITS'(2)))
        else $error("level length below two during interpolation");

    // Step counter stays inside the level
    a_step_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_step <= r_len - LEN_BITS'(2)))
        else $error("step counter past end of level");

    // A new result only comes from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");

endmodule
